// ===== src/wspid_pkg.sv =====
`default_nettype none

package wspid_pkg;

  localparam int FILT_W  = 25;
  localparam int ERR_W   = 26;
  localparam int INTEG_W = 26;
  localparam int DIFF_W  = 27;
  localparam int MA_W    = 27;
  localparam int MB_W    = 18;
  localparam int PROD_W  = 45;
  localparam int ACC_W   = 46;
  localparam int STEP_W  = 4;
  localparam int FRAC_W  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_BOUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd5;

  localparam logic [16:0] ALPHA_ONE       = 17'h10000;
  localparam logic [14:0] DRIVE_LIMIT_RST = 15'h7fff;

  // multiplier operand selects
  localparam logic [2:0] A_MEAS  = 3'd0;
  localparam logic [2:0] A_FILT  = 3'd1;
  localparam logic [2:0] A_ERR   = 3'd2;
  localparam logic [2:0] A_INTEG = 3'd3;
  localparam logic [2:0] A_DIFF  = 3'd4;

  localparam logic [2:0] B_ALPHA = 3'd0;
  localparam logic [2:0] B_OMA   = 3'd1;
  localparam logic [2:0] B_PGAIN = 3'd2;
  localparam logic [2:0] B_IGAIN = 3'd3;
  localparam logic [2:0] B_DGAIN = 3'd4;

  // accumulator ops
  localparam logic [1:0] ACC_HOLD  = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_ADD   = 2'd2;
  localparam logic [1:0] ACC_CLAMP = 2'd3;

  // state register writes
  localparam logic [2:0] WR_NONE       = 3'd0;
  localparam logic [2:0] WR_CLEAR      = 3'd1;
  localparam logic [2:0] WR_FILT_EMA   = 3'd2;
  localparam logic [2:0] WR_FILT_PRIME = 3'd3;
  localparam logic [2:0] WR_ERR        = 3'd4;
  localparam logic [2:0] WR_INTEG_DIFF = 3'd5;

  // sequencer jumps
  localparam logic [1:0] JMP_NONE     = 2'd0;
  localparam logic [1:0] JMP_ALWAYS   = 2'd1;
  localparam logic [1:0] JMP_UNPRIMED = 2'd2;

  localparam logic [STEP_W-1:0] STEP_START = 4'd0;
  localparam logic [STEP_W-1:0] STEP_PRIME = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ERR   = 4'd5;

  typedef struct packed {
    logic [2:0]        a_sel;
    logic [2:0]        b_sel;
    logic [1:0]        acc_op;
    logic [2:0]        wr_op;
    logic [1:0]        jmp;
    logic [STEP_W-1:0] dest;
    logic              last;
  } ctrl_t;

  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] integ_gain;
    logic signed [15:0] deriv_gain;
    logic [23:0]        integral_bound;
    logic [16:0]        filter_alpha;
    logic [14:0]        drive_limit;
  } cfg_t;

  localparam ctrl_t CTRL_IDLE = '{a_sel: A_MEAS, b_sel: B_ALPHA, acc_op: ACC_HOLD,
                                  wr_op: WR_NONE, jmp: JMP_NONE, dest: STEP_START,
                                  last: 1'b0};

  function automatic ctrl_t cw(input logic [2:0] a, input logic [2:0] b,
                               input logic [1:0] acc, input logic [2:0] wr,
                               input logic [1:0] jmp, input logic [STEP_W-1:0] dest,
                               input logic last);
    ctrl_t c;
    c.a_sel  = a;
    c.b_sel  = b;
    c.acc_op = acc;
    c.wr_op  = wr;
    c.jmp    = jmp;
    c.dest   = dest;
    c.last   = last;
    return c;
  endfunction

  // control program for one step transaction; a product issued in a step
  // is in the product register during the step executed after it
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] s);
    ctrl_t c;
    unique case (s)
      4'd0:  c = cw(A_MEAS,  B_ALPHA, ACC_HOLD,  WR_NONE,       JMP_UNPRIMED, STEP_PRIME,
                    1'b0);
      4'd1:  c = cw(A_FILT,  B_OMA,   ACC_LOAD,  WR_NONE,       JMP_NONE, STEP_START, 1'b0);
      4'd2:  c = cw(A_MEAS,  B_ALPHA, ACC_ADD,   WR_NONE,       JMP_NONE, STEP_START, 1'b0);
      4'd3:  c = cw(A_MEAS,  B_ALPHA, ACC_HOLD,  WR_FILT_EMA,   JMP_ALWAYS, STEP_ERR, 1'b0);
      4'd4:  c = cw(A_MEAS,  B_ALPHA, ACC_HOLD,  WR_FILT_PRIME, JMP_NONE, STEP_START, 1'b0);
      4'd5:  c = cw(A_MEAS,  B_ALPHA, ACC_HOLD,  WR_ERR,        JMP_NONE, STEP_START, 1'b0);
      4'd6:  c = cw(A_ERR,   B_PGAIN, ACC_HOLD,  WR_INTEG_DIFF, JMP_NONE, STEP_START, 1'b0);
      4'd7:  c = cw(A_INTEG, B_IGAIN, ACC_LOAD,  WR_NONE,       JMP_NONE, STEP_START, 1'b0);
      4'd8:  c = cw(A_DIFF,  B_DGAIN, ACC_ADD,   WR_NONE,       JMP_NONE, STEP_START, 1'b0);
      4'd9:  c = cw(A_MEAS,  B_ALPHA, ACC_ADD,   WR_NONE,       JMP_NONE, STEP_START, 1'b0);
      4'd10: c = cw(A_MEAS,  B_ALPHA, ACC_CLAMP, WR_NONE,       JMP_NONE, STEP_START, 1'b0);
      4'd11: c = cw(A_MEAS,  B_ALPHA, ACC_HOLD,  WR_NONE,       JMP_NONE, STEP_START, 1'b1);
      default: c = CTRL_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/wspid_if.sv =====
`default_nettype none

interface wspid_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] speed_ref;
  logic signed [15:0] speed_fb;

  modport source(output valid, action, speed_ref, speed_fb, input ready);
  modport sink(input valid, action, speed_ref, speed_fb, output ready);
endinterface

interface wspid_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive_value;

  modport source(output valid, drive_value, input ready);
  modport sink(input valid, drive_value, output ready);
endinterface

`default_nettype wire

// ===== src/wspid_datapath.sv =====
`default_nettype none

module wspid_datapath (
  input  wire                   clk,
  input  wire                   rst,
  input  wire wspid_pkg::ctrl_t ctrl,
  input  wire wspid_pkg::cfg_t  cfg,
  input  wire logic signed [15:0] target,
  input  wire logic signed [15:0] meas,
  output logic                  primed,
  output logic signed [15:0]    drive
);

  localparam int AW = wspid_pkg::ACC_W;
  localparam int FW = wspid_pkg::FRAC_W;

  logic signed [wspid_pkg::FILT_W-1:0]  filt;
  logic signed [wspid_pkg::ERR_W-1:0]   err;
  logic signed [wspid_pkg::INTEG_W-1:0] integ;
  logic signed [wspid_pkg::ERR_W-1:0]   prev;
  logic signed [wspid_pkg::DIFF_W-1:0]  diff;
  logic signed [wspid_pkg::PROD_W-1:0]  prod;
  logic signed [AW-1:0]                 acc;

  logic [16:0]                          alpha_eff;
  logic [16:0]                          oma;
  logic signed [23:0]                   meas256;
  logic signed [23:0]                   target256;
  logic signed [wspid_pkg::MA_W-1:0]    ma;
  logic signed [wspid_pkg::MB_W-1:0]    mb;
  logic signed [wspid_pkg::PROD_W-1:0]  prod_next;
  logic signed [AW-1:0]                 acc_next;
  logic signed [AW-1:0]                 acc_rnd;
  logic signed [AW-1:0]                 lim_pos;
  logic signed [AW-1:0]                 lim_neg;
  logic signed [wspid_pkg::DIFF_W-1:0]  isum;
  logic signed [wspid_pkg::DIFF_W-1:0]  bnd_pos;
  logic signed [wspid_pkg::DIFF_W-1:0]  bnd_neg;
  logic signed [wspid_pkg::DIFF_W-1:0]  isum_clamped;

  // zero or above one both mean no filtering
  assign alpha_eff = (cfg.filter_alpha == 17'd0 || cfg.filter_alpha > wspid_pkg::ALPHA_ONE)
                   ? wspid_pkg::ALPHA_ONE : cfg.filter_alpha;
  assign oma       = wspid_pkg::ALPHA_ONE - alpha_eff;
  assign meas256   = {meas, 8'h00};
  assign target256 = {target, 8'h00};

  always_comb begin
    unique case (ctrl.a_sel)
      wspid_pkg::A_MEAS:  ma = wspid_pkg::MA_W'(meas256);
      wspid_pkg::A_FILT:  ma = wspid_pkg::MA_W'(filt);
      wspid_pkg::A_ERR:   ma = wspid_pkg::MA_W'(err);
      wspid_pkg::A_INTEG: ma = wspid_pkg::MA_W'(integ);
      wspid_pkg::A_DIFF:  ma = diff;
      default:            ma = '0;
    endcase
    unique case (ctrl.b_sel)
      wspid_pkg::B_ALPHA: mb = {1'b0, alpha_eff};
      wspid_pkg::B_OMA:   mb = {1'b0, oma};
      wspid_pkg::B_PGAIN: mb = wspid_pkg::MB_W'(cfg.prop_gain);
      wspid_pkg::B_IGAIN: mb = wspid_pkg::MB_W'(cfg.integ_gain);
      wspid_pkg::B_DGAIN: mb = wspid_pkg::MB_W'(cfg.deriv_gain);
      default:            mb = '0;
    endcase
  end

  assign prod_next = ma * mb;

  // round to nearest, ties away from zero, on the 16 fraction bits
  assign acc_rnd = acc + (acc[AW-1] ? AW'((1 << (FW - 1)) - 1) : AW'(1 << (FW - 1)));
  assign drive   = acc_rnd[FW+15:FW];

  assign lim_pos = AW'({cfg.drive_limit, 16'h0000});
  assign lim_neg = -lim_pos;

  always_comb begin
    unique case (ctrl.acc_op)
      wspid_pkg::ACC_HOLD:  acc_next = acc;
      wspid_pkg::ACC_LOAD:  acc_next = AW'(prod);
      wspid_pkg::ACC_ADD:   acc_next = acc + AW'(prod);
      wspid_pkg::ACC_CLAMP: begin
        if (acc > lim_pos) begin
          acc_next = lim_pos;
        end else if (acc < lim_neg) begin
          acc_next = lim_neg;
        end else begin
          acc_next = acc;
        end
      end
      default:              acc_next = acc;
    endcase
  end

  assign isum    = wspid_pkg::DIFF_W'(integ) + wspid_pkg::DIFF_W'(err);
  assign bnd_pos = wspid_pkg::DIFF_W'(cfg.integral_bound);
  assign bnd_neg = -bnd_pos;

  always_comb begin
    priority if (isum > bnd_pos) begin
      isum_clamped = bnd_pos;
    end else if (isum < bnd_neg) begin
      isum_clamped = bnd_neg;
    end else begin
      isum_clamped = isum;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    acc  <= acc_next;
    if (ctrl.wr_op == wspid_pkg::WR_ERR) begin
      err <= wspid_pkg::ERR_W'(target256) - wspid_pkg::ERR_W'(filt);
    end
    if (ctrl.wr_op == wspid_pkg::WR_INTEG_DIFF) begin
      diff <= wspid_pkg::DIFF_W'(err) - wspid_pkg::DIFF_W'(prev);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt   <= '0;
      primed <= 1'b0;
      integ  <= '0;
      prev   <= '0;
    end else begin
      unique case (ctrl.wr_op)
        wspid_pkg::WR_CLEAR: begin
          filt   <= '0;
          primed <= 1'b0;
          integ  <= '0;
          prev   <= '0;
        end
        wspid_pkg::WR_FILT_EMA: begin
          filt   <= acc_rnd[FW+wspid_pkg::FILT_W-1:FW];
          primed <= 1'b1;
        end
        wspid_pkg::WR_FILT_PRIME: begin
          filt   <= wspid_pkg::FILT_W'(meas256);
          primed <= 1'b1;
        end
        wspid_pkg::WR_INTEG_DIFF: begin
          integ <= wspid_pkg::INTEG_W'(isum_clamped);
          prev  <= err;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/wheel_speed_pid_with_filter.sv =====
`default_nettype none
// Wheel speed PID with an EMA filter on the measured speed.
// request channel: action 0 runs one control step on speed_ref and
// speed_fb; action 1 clears filter, integral and previous error and
// gives no result. result channel: one drive_value per control step.
// Configuration: cfg_write/cfg_index/cfg_data write one register per cycle;
// the user must do so only while no transaction is in flight, as the block
// itself does not enforce it. The first step after reset or clear skips the
// filter math. The microcode program runs up to five products through one
// shared 27x18 multiplier; request.ready is low while the program runs, so a
// new step is accepted only after the last one finishes. A clear is taken
// while idle and starts no program.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the program holds on its final step
// until the output register frees up.
// Reset (synchronous, rst high) clears the state, the sequencer and the
// output valid flag and loads the register defaults.
module wheel_speed_pid_with_filter (
  input  wire                                    clk,
  input  wire                                    rst,
  wspid_req_if.sink                              request,
  wspid_rsp_if.source                            result,
  input  wire                                    cfg_write,
  input  wire logic [wspid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wspid_pkg::CFG_DATA_W-1:0]  cfg_data
);

  wspid_pkg::cfg_t   cfg;
  wspid_pkg::ctrl_t  rom;
  wspid_pkg::ctrl_t  ctrl;

  logic                          busy;
  logic [wspid_pkg::STEP_W-1:0]  step;
  logic signed [15:0]            target;
  logic signed [15:0]            meas;
  logic                          out_valid;
  logic signed [15:0]            out_data;
  logic                          primed;
  logic signed [15:0]            drive;
  logic                          req_take;
  logic                          stall;
  logic                          jump;

  assign request.ready      = !busy;
  assign result.valid       = out_valid;
  assign result.drive_value = out_data;

  assign req_take = request.valid && !busy;
  assign rom      = wspid_pkg::ucode(step);
  assign stall    = rom.last && out_valid && !result.ready;
  assign jump     = (rom.jmp == wspid_pkg::JMP_ALWAYS)
                 || (rom.jmp == wspid_pkg::JMP_UNPRIMED && !primed);

  always_comb begin
    ctrl = wspid_pkg::CTRL_IDLE;
    if (busy) begin
      ctrl = rom;
    end else if (req_take && request.action) begin
      ctrl.wr_op = wspid_pkg::WR_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= '0;
      cfg.integ_gain     <= '0;
      cfg.deriv_gain     <= '0;
      cfg.integral_bound <= '0;
      cfg.filter_alpha   <= wspid_pkg::ALPHA_ONE;
      cfg.drive_limit    <= wspid_pkg::DRIVE_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wspid_pkg::REG_PROP_GAIN:      cfg.prop_gain      <= cfg_data[15:0];
        wspid_pkg::REG_INTEG_GAIN:     cfg.integ_gain     <= cfg_data[15:0];
        wspid_pkg::REG_DERIV_GAIN:     cfg.deriv_gain     <= cfg_data[15:0];
        wspid_pkg::REG_INTEGRAL_BOUND: cfg.integral_bound <= cfg_data[23:0];
        wspid_pkg::REG_FILTER_ALPHA:   cfg.filter_alpha   <= cfg_data[16:0];
        wspid_pkg::REG_DRIVE_LIMIT:    cfg.drive_limit    <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_take && !request.action) begin
      target <= request.speed_ref;
      meas   <= request.speed_fb;
    end
    if (busy && rom.last && !stall) begin
      out_data <= drive;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= wspid_pkg::STEP_START;
      out_valid <= 1'b0;
    end else begin
      // a finishing program refills the output register as it drains
      if (busy && rom.last && !stall) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (busy) begin
        if (rom.last) begin
          if (!stall) begin
            busy <= 1'b0;
          end
        end else if (jump) begin
          step <= rom.dest;
        end else begin
          step <= step + 1'b1;
        end
      end else if (req_take && !request.action) begin
        busy <= 1'b1;
        step <= wspid_pkg::STEP_START;
      end
    end
  end

  wspid_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .target (target),
    .meas   (meas),
    .primed (primed),
    .drive  (drive)
  );

endmodule

`default_nettype wire

// ===== src/wspid_checker.sv =====
`default_nettype none

module wspid_checker (
  input wire               clk,
  input wire               rst,
  input wire               req_valid,
  input wire               req_ready,
  input wire               req_action,
  input wire               rsp_valid,
  input wire               rsp_ready,
  input wire logic [15:0]  rsp_drive
);

  // a stalled result holds its value
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
    else $error("result changed while stalled");

  // a step transaction occupies the controller
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !req_action |=> !req_ready)
    else $error("request taken again right after a step");

  // a result only appears at the end of a running program
  a_rsp_from_program: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared while idle");

  // a clear produces no result
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_action && !rsp_valid |=> !rsp_valid)
    else $error("clear produced a result");

endmodule

bind wheel_speed_pid_with_filter wspid_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (request.valid),
  .req_ready  (request.ready),
  .req_action (request.action),
  .rsp_valid  (result.valid),
  .rsp_ready  (result.ready),
  .rsp_drive  (result.drive_value)
);

`default_nettype wire
